[sv/utf8v_pkg.sv]
// Constants and the code point check shared by the strict UTF-8 validator.
package utf8v_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CpW   = 21;
  localparam int unsigned TailW = 2;
  localparam int unsigned ClsW  = 2;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [CpW-1:0]   cp_t;
  typedef logic [TailW-1:0] tail_t;

  // Sequence length class; it sets the smallest code point that is not overlong.
  typedef enum logic [ClsW-1:0] {
    CLS_NONE  = 2'd0,
    CLS_TWO   = 2'd1,
    CLS_THREE = 2'd2,
    CLS_FOUR  = 2'd3
  } seq_cls_t;

  localparam byte_t LEAD2_LO   = 8'hc2;
  localparam byte_t LEAD2_HI   = 8'hdf;
  localparam byte_t LEAD3_LO   = 8'he0;
  localparam byte_t LEAD3_HI   = 8'hef;
  localparam byte_t LEAD4_LO   = 8'hf0;
  localparam byte_t LEAD4_HI   = 8'hf4;
  localparam byte_t ASCII_TOP  = 8'h7f;

  localparam cp_t MIN_TWO      = 21'h000080;
  localparam cp_t MIN_THREE    = 21'h000800;
  localparam cp_t MIN_FOUR     = 21'h010000;
  localparam cp_t CP_MAX       = 21'h10ffff;
  localparam cp_t SURR_LO      = 21'h00d800;
  localparam cp_t SURR_HI      = 21'h00dfff;
  localparam cp_t CTRL_C0_END  = 21'h000020;
  localparam cp_t DEL_CP       = 21'h00007f;
  localparam cp_t C1_HI        = 21'h00009f;
  localparam cp_t BIDI_A_LO    = 21'h00202a;
  localparam cp_t BIDI_A_HI    = 21'h00202e;
  localparam cp_t BIDI_B_LO    = 21'h002066;
  localparam cp_t BIDI_B_HI    = 21'h002069;

  function automatic logic point_forbidden(input cp_t cp, input seq_cls_t cls);
    cp_t minimum;
    begin
      case (cls)
        CLS_TWO:   minimum = MIN_TWO;
        CLS_THREE: minimum = MIN_THREE;
        CLS_FOUR:  minimum = MIN_FOUR;
        default:   minimum = '0;
      endcase
      point_forbidden = (cp < minimum) || (cp > CP_MAX) ||
                        (cp inside {[SURR_LO:SURR_HI]}) ||
                        (cp < CTRL_C0_END) ||
                        (cp inside {[DEL_CP:C1_HI]}) ||
                        (cp inside {[BIDI_A_LO:BIDI_A_HI]}) ||
                        (cp inside {[BIDI_B_LO:BIDI_B_HI]});
    end
  endfunction

endpackage

[sv/strict_utf8_text_validator.sv]
// Strict UTF-8 validator: decode state, failure latch and output register.
//
// The block checks a text one byte per transfer and returns one result per input transfer,
// registered, at a sustained rate of one item per clock while out_stall is low. The decode state
// (tail count, partial code point, sequence class, failure latch) updates in the same cycle
// as the input transfer, and the result sits in an output register, so a new item is taken
// whenever the output register is empty or is being emptied in that cycle. A result with
// verdict_ready set closes the text; text_accepted then is the final verdict, and the next
// item starts a fresh text. Mid-text, text_accepted reports whether any failure has latched,
// not counting a sequence still in progress. No memories and no clearing pass after reset.
module strict_utf8_text_validator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  utf8v_pkg::byte_t     in_text_byte,
  input  logic                 in_byte_present,
  input  logic                 in_end_of_text,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_verdict_ready,
  output logic                 out_text_accepted
);
  import utf8v_pkg::*;

  tail_t    tail_left_r, tail_left_nxt;
  cp_t      partial_cp_r, partial_cp_nxt;
  seq_cls_t seq_cls_r, seq_cls_nxt;
  logic     failed_r, failed_nxt;
  logic     out_valid_r, out_valid_nxt;
  logic     verdict_r, verdict_nxt;
  logic     accepted_r, accepted_nxt;
  logic     in_xfer;
  cp_t      shifted_cp;
  tail_t    tail_dec;

  assign in_stall = out_valid_r && out_stall;
  assign in_xfer  = in_valid && !in_stall;

  assign shifted_cp = {partial_cp_r[CpW-7:0], in_text_byte[5:0]};
  assign tail_dec   = tail_left_r - tail_t'(1);

  always_comb begin
    tail_left_nxt  = tail_left_r;
    partial_cp_nxt = partial_cp_r;
    seq_cls_nxt    = seq_cls_r;
    failed_nxt     = failed_r;
    out_valid_nxt  = out_valid_r && out_stall;
    verdict_nxt    = verdict_r;
    accepted_nxt   = accepted_r;

    if (in_xfer) begin
      if (in_byte_present && !failed_r) begin
        if (tail_left_r == '0) begin
          if (in_text_byte <= ASCII_TOP) begin
            if (point_forbidden(cp_t'(in_text_byte), CLS_NONE)) begin
              failed_nxt = 1'b1;
            end
          end else if (in_text_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
            partial_cp_nxt = cp_t'(in_text_byte[4:0]);
            tail_left_nxt  = tail_t'(1);
            seq_cls_nxt    = CLS_TWO;
          end else if (in_text_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
            partial_cp_nxt = cp_t'(in_text_byte[3:0]);
            tail_left_nxt  = tail_t'(2);
            seq_cls_nxt    = CLS_THREE;
          end else if (in_text_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
            partial_cp_nxt = cp_t'(in_text_byte[2:0]);
            tail_left_nxt  = tail_t'(3);
            seq_cls_nxt    = CLS_FOUR;
          end else begin
            failed_nxt = 1'b1;
          end
        end else if (in_text_byte[7:6] != 2'b10) begin
          failed_nxt = 1'b1;
        end else begin
          tail_left_nxt = tail_dec;
          if (tail_dec == '0) begin
            // The sequence is complete: check the whole code point, then drop it.
            if (point_forbidden(shifted_cp, seq_cls_r)) begin
              failed_nxt = 1'b1;
            end
            partial_cp_nxt = '0;
            seq_cls_nxt    = CLS_NONE;
          end else begin
            partial_cp_nxt = shifted_cp;
          end
        end
      end

      // A sequence cut off by the end of the text fails the text.
      if (in_end_of_text && tail_left_nxt != '0) begin
        failed_nxt = 1'b1;
      end

      out_valid_nxt = 1'b1;
      verdict_nxt   = in_end_of_text;
      accepted_nxt  = !failed_nxt;

      if (in_end_of_text) begin
        tail_left_nxt  = '0;
        partial_cp_nxt = '0;
        seq_cls_nxt    = CLS_NONE;
        failed_nxt     = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tail_left_r  <= '0;
      partial_cp_r <= '0;
      seq_cls_r    <= CLS_NONE;
      failed_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      tail_left_r  <= tail_left_nxt;
      partial_cp_r <= partial_cp_nxt;
      seq_cls_r    <= seq_cls_nxt;
      failed_r     <= failed_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    verdict_r  <= verdict_nxt;
    accepted_r <= accepted_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_verdict_ready = verdict_r;
  assign out_text_accepted = accepted_r;

  // Between sequences no partial code point or class is left behind.
  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_left_r == '0) |-> (seq_cls_r == CLS_NONE && partial_cp_r == '0))
    else $error("decode state not clean between sequences");

  // An open sequence never expects more tails than its class allows.
  a_tail_fits_class: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_left_r != '0) |-> (seq_cls_r != CLS_NONE && tail_left_r <= tail_t'(seq_cls_r)))
    else $error("tail count exceeds sequence class");

  // The transfer that ends a text leaves the decoder in its reset state.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_end_of_text) |=> (tail_left_r == '0 && !failed_r))
    else $error("state not cleared after end of text");

  // A result that ends a text always follows an input transfer with the end marker.
  a_verdict_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> (verdict_r == $past(in_end_of_text)))
    else $error("verdict flag does not match the ending transfer");

endmodule

[verif/tb_strict_utf8_text_validator.sv]
// Self-checking testbench for the strict UTF-8 text validator: directed table, then random texts.
module tb_strict_utf8_text_validator;
  import utf8v_pkg::*;

  typedef struct packed {
    logic verdict_ready;
    logic text_accepted;
  } verdict_t;

  typedef struct packed {
    byte_t    data;
    logic     present;
    logic     last;
    logic     fixed;
    verdict_t verdict;
  } stim_row_t;

  localparam verdict_t OPEN_OK  = '{1'b0, 1'b1};
  localparam verdict_t OPEN_BAD = '{1'b0, 1'b0};
  localparam verdict_t DONE_OK  = '{1'b1, 1'b1};
  localparam verdict_t DONE_BAD = '{1'b1, 1'b0};

  localparam int RANDOM_ITEMS = 1800;
  localparam int PAUSE_EVERY  = 450;
  localparam int STALL_LIMIT  = 400;

  // Rows without a fixed verdict are checked against the decoder model.
  localparam stim_row_t DIRECTED_ROWS [0:27] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, DONE_OK},   // empty text
    '{8'h41, 1'b1, 1'b0, 1'b1, OPEN_OK},
    '{8'h00, 1'b1, 1'b1, 1'b1, DONE_BAD},  // C0 control
    '{8'h7f, 1'b1, 1'b1, 1'b1, DONE_BAD},  // DEL
    '{8'hff, 1'b1, 1'b1, 1'b1, DONE_BAD},
    '{8'hc2, 1'b1, 1'b0, 1'b1, OPEN_OK},   // unfinished sequence is not a failure yet
    '{8'h80, 1'b1, 1'b1, 1'b1, DONE_BAD},  // C1 control
    '{8'hc1, 1'b1, 1'b1, 1'b1, DONE_BAD},
    '{8'he0, 1'b1, 1'b0, 1'b0, OPEN_OK},   // overlong three-byte form
    '{8'h80, 1'b1, 1'b0, 1'b0, OPEN_OK},
    '{8'h80, 1'b1, 1'b1, 1'b1, DONE_BAD},
    '{8'hed, 1'b1, 1'b0, 1'b0, OPEN_OK},   // surrogate
    '{8'ha0, 1'b1, 1'b0, 1'b0, OPEN_OK},
    '{8'h80, 1'b1, 1'b1, 1'b1, DONE_BAD},
    '{8'he2, 1'b1, 1'b0, 1'b0, OPEN_OK},   // bidi control
    '{8'h80, 1'b1, 1'b0, 1'b0, OPEN_OK},
    '{8'haa, 1'b1, 1'b1, 1'b1, DONE_BAD},
    '{8'hf4, 1'b1, 1'b0, 1'b0, OPEN_OK},   // above the last code point
    '{8'h90, 1'b1, 1'b0, 1'b0, OPEN_OK},
    '{8'h80, 1'b1, 1'b0, 1'b0, OPEN_OK},
    '{8'h80, 1'b1, 1'b1, 1'b1, DONE_BAD},
    '{8'he2, 1'b1, 1'b0, 1'b0, OPEN_OK},   // cut off by a bare end marker
    '{8'h82, 1'b1, 1'b0, 1'b0, OPEN_OK},
    '{8'h5a, 1'b0, 1'b0, 1'b0, OPEN_OK},
    '{8'ha5, 1'b0, 1'b1, 1'b1, DONE_BAD},
    '{8'hc3, 1'b1, 1'b0, 1'b0, OPEN_OK},   // bad tail byte, later bytes ignored
    '{8'h41, 1'b1, 1'b0, 1'b1, OPEN_BAD},
    '{8'hc2, 1'b1, 1'b1, 1'b1, DONE_BAD}
  };

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  byte_t in_text_byte = '0;
  logic  in_byte_present = 1'b0;
  logic  in_end_of_text = 1'b0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  logic  out_verdict_ready;
  logic  out_text_accepted;

  // Fixed verdict that travels alongside the current input payload.
  logic     row_fixed = 1'b0;
  verdict_t row_verdict = '0;

  verdict_t expected_verdicts[$];
  byte_t    text_bytes[$];
  int       mismatches = 0;
  int       quiet_cycles = 0;
  int       items_sent = 0;
  int       rx_wait = 0;
  bit       tx_burst = 1'b0;
  bit       rx_burst = 1'b0;

  tail_t    dec_tail = '0;
  cp_t      dec_cp = '0;
  seq_cls_t dec_cls = CLS_NONE;
  logic     dec_failed = 1'b0;

  strict_utf8_text_validator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_text_byte      (in_text_byte),
    .in_byte_present   (in_byte_present),
    .in_end_of_text    (in_end_of_text),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_verdict_ready (out_verdict_ready),
    .out_text_accepted (out_text_accepted)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int draw_wait(input bit burst);
    if (burst || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 13);
  endfunction

  function automatic logic cp_rejected(input cp_t cp, input seq_cls_t cls);
    logic overlong;
    overlong = (cls == CLS_TWO && cp < MIN_TWO) || (cls == CLS_THREE && cp < MIN_THREE) ||
               (cls == CLS_FOUR && cp < MIN_FOUR);
    return overlong || cp > CP_MAX || cp < CTRL_C0_END ||
           (cp >= SURR_LO && cp <= SURR_HI) || (cp >= DEL_CP && cp <= C1_HI) ||
           (cp >= BIDI_A_LO && cp <= BIDI_A_HI) || (cp >= BIDI_B_LO && cp <= BIDI_B_HI);
  endfunction

  // Advances the decoder state by one item and returns the verdict it reports.
  task automatic utf8_decode_step(input byte_t b, input logic present, input logic last,
                                  output verdict_t v);
    if (present && !dec_failed) begin
      if (dec_tail == '0) begin
        if (b[7] == 1'b0) begin
          if (cp_rejected(cp_t'(b), CLS_NONE)) dec_failed = 1'b1;
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
          dec_cp = cp_t'(b[4:0]);
          dec_tail = 2'd1;
          dec_cls = CLS_TWO;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
          dec_cp = cp_t'(b[3:0]);
          dec_tail = 2'd2;
          dec_cls = CLS_THREE;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
          dec_cp = cp_t'(b[2:0]);
          dec_tail = 2'd3;
          dec_cls = CLS_FOUR;
        end else begin
          dec_failed = 1'b1;
        end
      end else if (b[7:6] != 2'b10) begin
        dec_failed = 1'b1;
      end else begin
        dec_cp = {dec_cp[CpW-7:0], b[5:0]};
        dec_tail = dec_tail - 2'd1;
        if (dec_tail == '0) begin
          if (cp_rejected(dec_cp, dec_cls)) dec_failed = 1'b1;
          dec_cp = '0;
          dec_cls = CLS_NONE;
        end
      end
    end
    if (last && dec_tail != '0) dec_failed = 1'b1;
    v.verdict_ready = last;
    v.text_accepted = !dec_failed;
    if (last) begin
      dec_tail = '0;
      dec_cp = '0;
      dec_cls = CLS_NONE;
      dec_failed = 1'b0;
    end
  endtask

  task automatic send_item(input byte_t data, input logic present, input logic last,
                           input logic fixed, input verdict_t fixed_verdict);
    int gap;
    gap = draw_wait(tx_burst);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_text_byte <= data;
    in_byte_present <= present;
    in_end_of_text <= last;
    row_fixed <= fixed;
    row_verdict <= fixed_verdict;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
  endtask

  // Holds the sender off until every outstanding verdict has been returned.
  task automatic wait_for_verdicts();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_verdicts.size() != 0);
    @(posedge clk);
  endtask

  // Builds one text, mostly well-formed characters with a few damaged texts, and sends it.
  task automatic send_random_text();
    logic [31:0] cp;
    int len;
    int pick;
    int pos;
    bit bare_end;
    text_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 6)) text_bytes.push_back(byte_t'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 8)) begin
        pick = $urandom_range(0, 99);
        len = 3;
        if (pick < 40) begin
          len = 1;
          cp = $urandom_range(32'h20, 32'h7e);
        end else if (pick < 48) begin
          len = 1;
          cp = $urandom_range(0, 32'h7f);
        end else if (pick < 58) begin
          len = 2;
          cp = $urandom_range(32'h80, 32'h7ff);
        end else if (pick < 62) begin
          len = 2;
          cp = $urandom_range(32'h7c, 32'ha3);
        end else if (pick < 74) begin
          cp = $urandom_range(32'h800, 32'hffff);
        end else if (pick < 82) begin
          // Edges of the bidi control and surrogate ranges.
          case ($urandom_range(0, 3))
            0: cp = 32'h2028 + $urandom_range(0, 7);
            1: cp = 32'h2064 + $urandom_range(0, 6);
            2: cp = 32'hd7fe + $urandom_range(0, 3);
            default: cp = 32'hdffe + $urandom_range(0, 3);
          endcase
        end else if (pick < 91) begin
          len = 4;
          cp = $urandom_range(32'h10000, 32'h10ffff);
        end else if (pick < 94) begin
          len = 4;
          cp = 32'h10fffe + $urandom_range(0, 3);
        end else if (pick < 97) begin
          len = $urandom_range(2, 4);
          cp = $urandom_range(0, len == 2 ? 32'h7f : len == 3 ? 32'h7ff : 32'hffff);
        end else begin
          len = 4;
          cp = $urandom_range(32'h110000, 32'h1fffff);
        end
        case (len)
          1: text_bytes.push_back(byte_t'(cp[6:0]));
          2: begin
            text_bytes.push_back({3'b110, cp[10:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
          end
          3: begin
            text_bytes.push_back({4'b1110, cp[15:12]});
            text_bytes.push_back({2'b10, cp[11:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
          end
          default: begin
            text_bytes.push_back({5'b11110, cp[20:18]});
            text_bytes.push_back({2'b10, cp[17:12]});
            text_bytes.push_back({2'b10, cp[11:6]});
            text_bytes.push_back({2'b10, cp[5:0]});
          end
        endcase
      end
      if (text_bytes.size() != 0 && $urandom_range(0, 4) == 0) begin
        pos = $urandom_range(0, text_bytes.size() - 1);
        case ($urandom_range(0, 3))
          0: text_bytes[pos] = byte_t'($urandom_range(0, 255));
          1: text_bytes.insert(pos, byte_t'($urandom_range(8'h80, 8'hbf)));
          2: text_bytes.delete(text_bytes.size() - 1);
          default: text_bytes.delete(pos);
        endcase
      end
    end
    bare_end = (text_bytes.size() == 0) || ($urandom_range(0, 3) == 0);
    foreach (text_bytes[i]) begin
      if ($urandom_range(0, 11) == 0) send_item(byte_t'($urandom), 1'b0, 1'b0, 1'b0, '0);
      send_item(text_bytes[i], 1'b1, !bare_end && i == text_bytes.size() - 1, 1'b0, '0);
    end
    if (bare_end) send_item(byte_t'($urandom), 1'b0, 1'b1, 1'b0, '0);
  endtask

  // Result side: the stall length for the next transfer is drawn when one completes.
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if ($urandom_range(0, 59) == 0) rx_burst = !rx_burst;
      rx_wait = draw_wait(rx_burst);
    end else if (rx_wait != 0) begin
      rx_wait--;
    end
    out_stall <= (rx_wait != 0);
  end

  always @(posedge clk) begin
    verdict_t want;
    verdict_t seen;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        seen = '{out_verdict_ready, out_text_accepted};
        if (expected_verdicts.size() == 0) begin
          $display("%0t: unexpected result, got verdict_ready %0b text_accepted %0b",
                   $time, seen.verdict_ready, seen.text_accepted);
          mismatches++;
        end else begin
          want = expected_verdicts.pop_front();
          if (seen.verdict_ready !== want.verdict_ready) begin
            $display("%0t: verdict_ready expected %0b, got %0b",
                     $time, want.verdict_ready, seen.verdict_ready);
            mismatches++;
          end
          if (seen.text_accepted !== want.text_accepted) begin
            $display("%0t: text_accepted expected %0b, got %0b",
                     $time, want.text_accepted, seen.text_accepted);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        utf8_decode_step(in_text_byte, in_byte_present, in_end_of_text, want);
        if (row_fixed) want = row_verdict;
        expected_verdicts.push_back(want);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("[strict_utf8_text_validator] ERROR");
        $finish;
      end
    end
  end

  initial begin
    int next_pause;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED_ROWS[r]) begin
      send_item(DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].present, DIRECTED_ROWS[r].last,
                DIRECTED_ROWS[r].fixed, DIRECTED_ROWS[r].verdict);
    end
    wait_for_verdicts();
    next_pause = items_sent + PAUSE_EVERY;
    while (items_sent < $size(DIRECTED_ROWS) + RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
      send_random_text();
      if (items_sent >= next_pause) begin
        wait_for_verdicts();
        next_pause = items_sent + PAUSE_EVERY;
      end
    end
    wait_for_verdicts();
    repeat (4) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && expected_verdicts.size() == 0) begin
      $display("[strict_utf8_text_validator] OK");
    end else begin
      $display("[strict_utf8_text_validator] ERROR");
    end
    $finish;
  end

endmodule

[sim.f]
sv/utf8v_pkg.sv
sv/strict_utf8_text_validator.sv
verif/tb_strict_utf8_text_validator.sv
